>>> design/gld_pkg.sv
// shared types and constants for the gif lzw decoder
`default_nettype none
package gld_pkg;
  localparam int unsigned MaxCodeBits = 12;
  localparam int unsigned TableSize   = 1 << MaxCodeBits;
  localparam int unsigned BufBits     = 24;

  typedef logic [MaxCodeBits-1:0] code_t;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_PUSH  = 2'd1,
    MODE_PULL  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_PIXEL    = 3'd1,
    ST_NEED     = 3'd2,
    ST_REFUSED  = 3'd3,
    ST_END      = 3'd4,
    ST_BADSIZE  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DECODE = 2'd1,
    PH_ENDED  = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] pixel_index;
  } out_t;
endpackage
`default_nettype wire

>>> design/gif_lzw_decoder.sv
// gif lzw decoder: start, push and pull commands over a table walk sequencer
//
// One command is taken when start_i is high and busy_o is low. Its single
// result appears on result_o for one cycle with done_o high, and cannot be
// held off. A start with a valid size first clears the string table, one
// entry a cycle. A pull that must decode a code walks the prefix chain in
// the S_WALK and S_ADD states for each table entry, because the table
// memory has one read port with registered data. A clear code met during a
// pull adds another sweep of the table.
`default_nettype none
module gif_lzw_decoder (
  input  wire  logic          clk_i,
  input  wire  logic          rst_ni,
  input  wire  logic          start_i,
  input  wire  gld_pkg::in_t  cmd_i,
  output logic                busy_o,
  output logic                done_o,
  output gld_pkg::out_t       result_o
);
  localparam int unsigned AW = gld_pkg::MaxCodeBits;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EXEC  = 9'b000000010,
    S_CLEAR = 9'b000000100,
    S_POP   = 9'b000001000,
    S_CODE  = 9'b000010000,
    S_WALK  = 9'b000100000,
    S_WAIT  = 9'b001000000,
    S_ADD   = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // string table and pixel stack memories
  logic [AW-1:0] prefix_mem [gld_pkg::TableSize];
  logic [7:0]    suffix_mem [gld_pkg::TableSize];
  logic [7:0]    stack_mem  [gld_pkg::TableSize];
  logic [AW-1:0] pre_rd_q;
  logic [7:0]    suf_rd_q, stk_rd_q;
  logic          tw_en;
  logic [AW-1:0] tw_addr, tw_pre, tr_addr;
  logic [7:0]    tw_suf;
  logic          sw_en;
  logic [AW-1:0] sw_addr, sr_addr;
  logic [7:0]    sw_data;

  always_ff @(posedge clk_i) begin
    if (tw_en) begin
      prefix_mem[tw_addr] <= tw_pre;
      suffix_mem[tw_addr] <= tw_suf;
    end
    pre_rd_q <= prefix_mem[tr_addr];
    suf_rd_q <= suffix_mem[tr_addr];
    if (sw_en) stack_mem[sw_addr] <= sw_data;
    stk_rd_q <= stack_mem[sr_addr];
  end

  // decoder registers
  logic [AW:0]   sp_q, sp_d;
  logic [3:0]    root_q, root_d, width_q, width_d;
  logic [AW:0]   nfc_q, nfc_d, lim_q, lim_d;
  logic [7:0]    first_q, first_d;
  logic [AW-1:0] prev_q, prev_d, cur_q, cur_d, code_q, code_d;
  logic [23:0]   buf_q, buf_d;
  logic [4:0]    held_q, held_d;
  logic [7:0]    left_q, left_d;
  logic [1:0]    phase_q, phase_d;
  logic          fresh_q, fresh_d;
  logic [AW:0]   clr_cnt_q, clr_cnt_d;
  gld_pkg::in_t  cmd_q, cmd_d;
  gld_pkg::out_t res_q, res_d;
  logic          done_q, done_d;

  logic [AW:0]   clr_val;
  logic [15:0]   code_mask;
  logic [AW:0]   code_ext;
  logic [23:0]   shifted_byte;
  logic [AW:0]   nfc_inc;

  assign clr_val      = (AW+1)'(1) << root_q;
  assign code_mask    = (16'(1) << width_q) - 16'(1);
  assign code_ext     = {1'b0, code_q};
  assign shifted_byte = {16'd0, cmd_q.data_byte} << held_q;
  assign nfc_inc      = nfc_q + (AW+1)'(1);

  always_comb begin
    state_d = state_q;
    sp_d = sp_q; root_d = root_q; width_d = width_q; nfc_d = nfc_q; lim_d = lim_q;
    first_d = first_q; prev_d = prev_q; cur_d = cur_q; code_d = code_q;
    buf_d = buf_q; held_d = held_q; left_d = left_q; phase_d = phase_q;
    fresh_d = fresh_q; clr_cnt_d = clr_cnt_q; cmd_d = cmd_q;
    res_d = res_q; done_d = 1'b0;
    tw_en = 1'b0; tw_addr = clr_cnt_q[AW-1:0]; tw_pre = '0; tw_suf = '0;
    tr_addr = cur_q;
    sw_en = 1'b0; sw_addr = sp_q[AW-1:0]; sw_data = '0;
    sr_addr = sp_q[AW-1:0] - AW'(1);

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_i;
          state_d = S_EXEC;
        end
      end
      // dispatch one command
      S_EXEC: begin
        res_d = '{status: gld_pkg::ST_ACCEPTED, pixel_index: 8'd0};
        state_d = S_RESP;
        case (cmd_q.mode)
          gld_pkg::MODE_START: begin
            if (!(cmd_q.data_byte inside {[8'd2:8'd8]})) begin
              phase_d = gld_pkg::PH_IDLE;
              fresh_d = 1'b0;
              res_d.status = gld_pkg::ST_BADSIZE;
            end else begin
              root_d = cmd_q.data_byte[3:0];
              first_d = '0; prev_d = '0; buf_d = '0; held_d = '0; left_d = '0;
              phase_d = gld_pkg::PH_DECODE;
              fresh_d = 1'b1;
              clr_cnt_d = '0;
              state_d = S_CLEAR;
            end
          end
          gld_pkg::MODE_PUSH: begin
            if (phase_q == gld_pkg::PH_IDLE) begin
              res_d.status = gld_pkg::ST_REFUSED;
            end else if (phase_q == gld_pkg::PH_DECODE) begin
              if (left_q == 8'd0) begin
                if (cmd_q.data_byte == 8'd0) phase_d = gld_pkg::PH_ENDED;
                else left_d = cmd_q.data_byte;
              end else if (held_q > 5'd16) begin
                res_d.status = gld_pkg::ST_REFUSED;
              end else begin
                buf_d = buf_q | shifted_byte;
                held_d = held_q + 5'd8;
                left_d = left_q - 8'd1;
              end
            end
          end
          gld_pkg::MODE_PULL: begin
            if (phase_q inside {gld_pkg::PH_IDLE, gld_pkg::PH_DONE}) begin
              res_d.status = gld_pkg::ST_END;
            end else begin
              state_d = S_POP;
            end
          end
          default: ;
        endcase
      end
      // sweep the table back to roots, then reset the code state
      S_CLEAR: begin
        tw_en = 1'b1;
        tw_suf = (clr_cnt_q < clr_val) ? clr_cnt_q[7:0] : 8'd0;
        clr_cnt_d = clr_cnt_q + (AW+1)'(1);
        if (clr_cnt_q[AW-1:0] == '1) begin
          width_d = root_q + 4'd1;
          lim_d = clr_val << 1;
          nfc_d = clr_val + (AW+1)'(2);
          sp_d = '0;
          state_d = (cmd_q.mode == gld_pkg::MODE_PULL) ? S_POP : S_RESP;
        end
      end
      // pop a waiting pixel or fetch the next code
      S_POP: begin
        if (sp_q != '0) begin
          sp_d = sp_q - (AW+1)'(1);
          state_d = S_WAIT;
        end else if (held_q < {1'b0, width_q}) begin
          state_d = S_RESP;
          res_d.pixel_index = 8'd0;
          if (phase_q == gld_pkg::PH_ENDED) begin
            phase_d = gld_pkg::PH_DONE;
            res_d.status = gld_pkg::ST_END;
          end else begin
            res_d.status = gld_pkg::ST_NEED;
          end
        end else begin
          code_d = AW'(buf_q[15:0] & code_mask);
          buf_d = buf_q >> width_q;
          held_d = held_q - {1'b0, width_q};
          state_d = S_CODE;
        end
      end
      S_WAIT: begin
        res_d = '{status: gld_pkg::ST_PIXEL, pixel_index: stk_rd_q};
        state_d = S_RESP;
      end
      // classify the fetched code
      S_CODE: begin
        state_d = S_RESP;
        res_d = '{status: gld_pkg::ST_END, pixel_index: 8'd0};
        if (code_ext == clr_val) begin
          fresh_d = 1'b1;
          clr_cnt_d = '0;
          state_d = S_CLEAR;
        end else if (code_ext == clr_val + (AW+1)'(1)) begin
          phase_d = gld_pkg::PH_DONE;
        end else if (fresh_q) begin
          if (code_ext > clr_val) begin
            phase_d = gld_pkg::PH_DONE;
          end else begin
            fresh_d = 1'b0;
            first_d = code_q[7:0];
            prev_d = code_q;
            res_d = '{status: gld_pkg::ST_PIXEL, pixel_index: code_q[7:0]};
          end
        end else if (code_ext > nfc_q) begin
          phase_d = gld_pkg::PH_DONE;
        end else begin
          cur_d = code_q;
          if (code_ext == nfc_q) begin
            sw_en = sp_q[AW] == 1'b0;
            sw_data = first_q;
            if (!sp_q[AW]) sp_d = sp_q + (AW+1)'(1);
            cur_d = prev_q;
          end
          state_d = S_WALK;
        end
      end
      // walk the prefix chain, one entry per S_WALK and S_ADD pass (read lands next cycle)
      S_WALK: begin
        tr_addr = cur_q;
        if ({1'b0, cur_q} >= clr_val) begin
          state_d = S_ADD;
        end else begin
          first_d = cur_q[7:0];
          sw_en = !sp_q[AW];
          sw_data = cur_q[7:0];
          if (!sp_q[AW]) sp_d = sp_q + (AW+1)'(1);
          // add the new table entry
          if (!nfc_q[AW]) begin
            tw_en = 1'b1;
            tw_addr = nfc_q[AW-1:0];
            tw_pre = prev_q;
            tw_suf = cur_q[7:0];
            nfc_d = nfc_inc;
            if (nfc_inc >= lim_q && !lim_q[AW]) begin
              lim_d = lim_q << 1;
              width_d = width_q + 4'd1;
            end
          end
          prev_d = code_q;
          state_d = S_POP;
        end
      end
      S_ADD: begin
        sw_en = !sp_q[AW];
        sw_data = suf_rd_q;
        if (!sp_q[AW]) sp_d = sp_q + (AW+1)'(1);
        cur_d = pre_rd_q;
        state_d = S_WALK;
      end
      S_RESP: begin
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q <= '0; root_q <= '0; width_q <= '0; nfc_q <= '0; lim_q <= '0;
      first_q <= '0; prev_q <= '0; buf_q <= '0; held_q <= '0; left_q <= '0;
      phase_q <= gld_pkg::PH_IDLE; fresh_q <= 1'b0; done_q <= 1'b0;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      sp_q <= sp_d; root_q <= root_d; width_q <= width_d; nfc_q <= nfc_d;
      lim_q <= lim_d; first_q <= first_d; prev_q <= prev_d; buf_q <= buf_d;
      held_q <= held_d; left_q <= left_d; phase_q <= phase_d;
      fresh_q <= fresh_d; done_q <= done_d; clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; code_q <= code_d; cmd_q <= cmd_d; res_q <= res_d;
  end

  assign busy_o   = state_q != S_IDLE;
  assign done_o   = done_q;
  assign result_o = res_q;

  // checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("result without return to idle");
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= (AW+1)'(gld_pkg::TableSize)) else $error("stack overflow");
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= 5'd24) else $error("bit buffer overfilled");
endmodule
`default_nettype wire

>>> bench/gif_lzw_decoder_tb.sv
// self-checking bench for the gif lzw decoder: scoreboard class, stream builder and drivers
`default_nettype none
module gif_lzw_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned TailCycles = 64;

  // decoder predictor and store of pending results
  class lzw_scoreboard;
    logic [11:0] prefix_tab [gld_pkg::TableSize];
    logic [7:0]  suffix_tab [gld_pkg::TableSize];
    logic [7:0]  stack_mem [gld_pkg::TableSize];
    int unsigned sp, roots, width, nfc, wlimit, first_ch, prev_code;
    int unsigned bitbuf, nbits, blk_left;
    gld_pkg::phase_e phase;
    bit          fresh;
    gld_pkg::out_t pending[$];
    int          errors;

    function new();
      fill(256);
      foreach (stack_mem[i]) stack_mem[i] = '0;
      sp = 0; roots = 0; width = 0; nfc = 0; wlimit = 0; first_ch = 0;
      prev_code = 0; bitbuf = 0; nbits = 0; blk_left = 0;
      phase = gld_pkg::PH_IDLE; fresh = 0; errors = 0;
    endfunction

    function void fill(int unsigned n);
      foreach (prefix_tab[i]) begin
        prefix_tab[i] = '0;
        suffix_tab[i] = (i < n) ? i[7:0] : 8'd0;
      end
    endfunction

    function void restart();
      int unsigned clr;
      clr = 1 << roots;
      fill(clr);
      width = roots + 1; wlimit = clr << 1; nfc = clr + 2; sp = 0;
    endfunction

    function void push_pix(int unsigned v);
      if (sp < gld_pkg::TableSize) begin
        stack_mem[sp & (gld_pkg::TableSize-1)] = v[7:0];
        sp++;
      end
    endfunction

    function gld_pkg::status_e start_image(int unsigned size);
      if (size < 2 || size > 8) begin
        phase = gld_pkg::PH_IDLE; fresh = 0;
        return gld_pkg::ST_BADSIZE;
      end
      roots = size;
      restart();
      first_ch = 0; prev_code = 0; bitbuf = 0; nbits = 0; blk_left = 0;
      phase = gld_pkg::PH_DECODE; fresh = 1;
      return gld_pkg::ST_ACCEPTED;
    endfunction

    function gld_pkg::status_e push_byte(int unsigned b);
      if (phase == gld_pkg::PH_IDLE) return gld_pkg::ST_REFUSED;
      if (phase != gld_pkg::PH_DECODE) return gld_pkg::ST_ACCEPTED;
      // count byte opens a sub-block, zero ends the data
      if (blk_left == 0) begin
        if (b == 0) phase = gld_pkg::PH_ENDED;
        else blk_left = b;
        return gld_pkg::ST_ACCEPTED;
      end
      if (nbits + 8 > gld_pkg::BufBits) return gld_pkg::ST_REFUSED;
      bitbuf = (bitbuf | (b << nbits)) & 32'hFF_FFFF;
      nbits += 8;
      blk_left--;
      return gld_pkg::ST_ACCEPTED;
    endfunction

    function gld_pkg::status_e pull(output logic [7:0] pix);
      int unsigned code, cur, clr;
      pix = '0;
      if (phase == gld_pkg::PH_IDLE || phase == gld_pkg::PH_DONE) return gld_pkg::ST_END;
      while (1) begin
        if (sp > 0) begin
          sp--;
          pix = stack_mem[sp & (gld_pkg::TableSize-1)];
          return gld_pkg::ST_PIXEL;
        end
        if (nbits < width) begin
          if (phase == gld_pkg::PH_ENDED) begin
            phase = gld_pkg::PH_DONE;
            return gld_pkg::ST_END;
          end
          return gld_pkg::ST_NEED;
        end
        code = bitbuf & ((1 << width) - 1);
        bitbuf = bitbuf >> width;
        nbits -= width;
        clr = 1 << roots;
        if (code == clr) begin
          restart();
          fresh = 1;
          continue;
        end
        if (code == clr + 1) begin
          phase = gld_pkg::PH_DONE;
          return gld_pkg::ST_END;
        end
        // first code after a clear is a bare root
        if (fresh) begin
          if (code > clr) begin
            phase = gld_pkg::PH_DONE;
            return gld_pkg::ST_END;
          end
          fresh = 0; first_ch = code & 8'hFF; prev_code = code;
          pix = code[7:0];
          return gld_pkg::ST_PIXEL;
        end
        if (code > nfc) begin
          phase = gld_pkg::PH_DONE;
          return gld_pkg::ST_END;
        end
        cur = code;
        // code not yet in the table: previous string plus its first char
        if (code == nfc) begin
          push_pix(first_ch);
          cur = prev_code;
        end
        while (cur >= clr) begin
          push_pix(suffix_tab[cur & (gld_pkg::TableSize-1)]);
          cur = prefix_tab[cur & (gld_pkg::TableSize-1)];
        end
        first_ch = cur & 8'hFF;
        push_pix(first_ch);
        if (nfc < gld_pkg::TableSize) begin
          prefix_tab[nfc] = prev_code[11:0];
          suffix_tab[nfc] = first_ch[7:0];
          nfc++;
          if (nfc >= wlimit && wlimit < gld_pkg::TableSize) begin
            wlimit = wlimit << 1;
            width++;
          end
        end
        prev_code = code;
      end
      return gld_pkg::ST_END;
    endfunction

    // note an accepted command and queue its result
    function gld_pkg::status_e note(gld_pkg::in_t c);
      gld_pkg::out_t r;
      logic [7:0] pix;
      gld_pkg::status_e st;
      pix = '0;
      st = gld_pkg::ST_ACCEPTED;
      case (c.mode)
        gld_pkg::MODE_START: st = start_image(c.data_byte);
        gld_pkg::MODE_PUSH:  st = push_byte(c.data_byte);
        gld_pkg::MODE_PULL:  st = pull(pix);
        default:             st = gld_pkg::ST_ACCEPTED;
      endcase
      r.status = st;
      r.pixel_index = (st == gld_pkg::ST_PIXEL) ? pix : 8'd0;
      pending.push_back(r);
      return st;
    endfunction

    // compare one result with the oldest pending one
    function void check(gld_pkg::out_t got);
      gld_pkg::out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status %0d pixel %0d", $time, got.status,
                 got.pixel_index);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, want.status,
                 got.status);
        errors++;
      end
      if (got.pixel_index !== want.pixel_index) begin
        $display("%0t: pixel mismatch expected %0d actual %0d", $time,
                 want.pixel_index, got.pixel_index);
        errors++;
      end
    endfunction
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  gld_pkg::in_t  cmd_i = '0;
  logic  busy_o, done_o;
  gld_pkg::out_t result_o;

  lzw_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned n_items = 0;
  int unsigned idle_pct = 0;

  // code stream under construction
  int unsigned code_q[$];
  logic [7:0]  raw_q[$];
  logic [7:0]  byte_q[$];
  int unsigned enc_clear, enc_width, enc_nfc, enc_limit, bit_acc, bit_cnt;
  bit          enc_fresh;

  gif_lzw_decoder u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result monitor, sampled mid-cycle
  always @(negedge clk_i) begin
    if (rst_ni && done_o) sb.check(result_o);
  end

  task automatic idle_gap();
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // one command transfer; returns the predicted status
  task automatic send(input logic [1:0] m, input logic [7:0] b,
                      output gld_pkg::status_e st);
    gld_pkg::in_t c;
    c.mode = m;
    c.data_byte = b;
    idle_gap();
    cmd_i <= c;
    start_i <= 1'b1;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    st = sb.note(c);
    n_items++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // encoder side tracking of code width
  task automatic enc_reset(int unsigned size);
    enc_clear = 1 << size;
    enc_width = size + 1;
    enc_nfc = enc_clear + 2;
    enc_limit = enc_clear << 1;
    enc_fresh = 1;
  endtask

  task automatic emit(int unsigned code);
    code_q.push_back(code);
    bit_acc = bit_acc | (code << bit_cnt);
    bit_cnt += enc_width;
    while (bit_cnt >= 8) begin
      raw_q.push_back(bit_acc[7:0]);
      bit_acc = bit_acc >> 8;
      bit_cnt -= 8;
    end
    if (code == enc_clear) enc_reset(enc_width == 0 ? 2 : $clog2(enc_clear));
    else if (code == enc_clear + 1) ;
    else if (enc_fresh) enc_fresh = 0;
    else if (enc_nfc < gld_pkg::TableSize) begin
      enc_nfc++;
      if (enc_nfc >= enc_limit && enc_limit < gld_pkg::TableSize) begin
        enc_limit = enc_limit << 1;
        enc_width++;
      end
    end
  endtask

  task automatic begin_stream(int unsigned size);
    code_q.delete(); raw_q.delete(); byte_q.delete();
    bit_acc = 0; bit_cnt = 0;
    enc_reset(size);
  endtask

  // flush bits and cut into counted sub-blocks with a zero terminator
  task automatic end_stream();
    int unsigned cnt;
    if (bit_cnt > 0) raw_q.push_back(bit_acc[7:0]);
    while (raw_q.size() != 0) begin
      cnt = ($urandom_range(9) == 0) ? 255 : $urandom_range(1, 12);
      if (cnt > raw_q.size()) cnt = raw_q.size();
      byte_q.push_back(cnt[7:0]);
      repeat (cnt) byte_q.push_back(raw_q.pop_front());
    end
    byte_q.push_back(8'd0);
  endtask

  // random well-formed codes, with a little corruption when noisy
  task automatic random_stream(int unsigned size, int unsigned n, bit noisy, bit roots_only);
    int unsigned code, r, top;
    begin_stream(size);
    emit(enc_clear);
    repeat (n) begin
      r = $urandom_range(99);
      top = (enc_nfc < gld_pkg::TableSize) ? enc_nfc : gld_pkg::TableSize - 1;
      if (noisy && r < 5) code = $urandom_range((1 << enc_width) - 1);
      else if (enc_fresh || roots_only || r < 45) code = $urandom_range(enc_clear - 1);
      else if (r < 48) code = enc_clear;
      else code = $urandom_range(enc_clear + 2, top);
      emit(code);
    end
    if ($urandom_range(9) != 0) emit(enc_clear + 1);
    end_stream();
  endtask

  // run one image: start, then interleave pushes and pulls until it ends
  task automatic run_image(int unsigned size);
    gld_pkg::status_e st;
    bit want_bits, refused;
    send(gld_pkg::MODE_START, size[7:0], st);
    if (st != gld_pkg::ST_ACCEPTED) return;
    want_bits = 0;
    refused = 0;
    while (1) begin
      if (byte_q.size() != 0 && !refused && (want_bits || $urandom_range(99) < 50)) begin
        send(gld_pkg::MODE_PUSH, byte_q[0], st);
        if (st == gld_pkg::ST_ACCEPTED) void'(byte_q.pop_front());
        else refused = 1;
      end else begin
        send(gld_pkg::MODE_PULL, 8'd0, st);
        if (st == gld_pkg::ST_END) break;
        want_bits = (st == gld_pkg::ST_NEED);
        refused = 0;
      end
    end
    // leftovers after the end are swallowed
    if (byte_q.size() != 0 && $urandom_range(1)) send(gld_pkg::MODE_PUSH, byte_q[0], st);
  endtask

  task automatic directed_image(int unsigned size, int unsigned codes[$]);
    begin_stream(size);
    foreach (codes[i]) emit(codes[i]);
    end_stream();
    run_image(size);
  endtask

  initial begin
    gld_pkg::status_e st;
    int unsigned phase_pct[3] = '{0, 84, 27};
    int unsigned img;
    int unsigned wait_cycles;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle block: pull ends, push refused, bad sizes, unused mode
    send(gld_pkg::MODE_PULL, 8'd0, st);
    send(gld_pkg::MODE_PUSH, 8'hA5, st);
    send(gld_pkg::MODE_START, 8'd0, st);
    send(gld_pkg::MODE_START, 8'd1, st);
    send(gld_pkg::MODE_START, 8'd9, st);
    send(gld_pkg::MODE_START, 8'd255, st);
    send(MODE_UNUSED, 8'hFF, st);
    // not-yet-in-table code, repeated clears, end code
    directed_image(2, '{4, 1, 6, 4, 4, 3, 5});
    // widest roots, stream ending without an end code
    directed_image(8, '{256, 255, 0, 258, 259});
    // fresh code above clear is corrupt
    directed_image(2, '{4, 7});
    // code beyond the next free entry is corrupt
    directed_image(3, '{8, 0, 12});
    send(gld_pkg::MODE_PUSH, 8'h5A, st);
    send(gld_pkg::MODE_PULL, 8'd0, st);

    // hold off until everything is back
    drain();

    // random images across idling phases
    img = 0;
    while (n_items < 1750) begin
      idle_pct = phase_pct[(img / 4) % 3];
      case ($urandom_range(9))
        0: send(gld_pkg::MODE_START, 8'($urandom_range(9, 255)), st);
        1: send(2'($urandom_range(1, 3)), 8'($urandom), st);
        default: begin
          random_stream($urandom_range(2, 8), $urandom_range(3, 40),
                        $urandom_range(4) == 0, 0);
          run_image(code_q.size() == 0 ? 2 : $clog2(code_q[0]));
        end
      endcase
      img++;
    end

    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    wait_cycles = 0;
    while (wait_cycles < TailCycles) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
design/gld_pkg.sv
design/gif_lzw_decoder.sv
bench/gif_lzw_decoder_tb.sv
